// ===== rtl/core/sfr_pkg.sv =====
package sfr_pkg;

  // Default number of message bytes one store bank holds.
  localparam int STORE_DEPTH_DEF = 16;

  // Field widths of the channels.
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int CNT_W    = 5;
  localparam int CFG_IDX_W = 2;
  localparam int M_TDATA_W = 16;

  // Number of frame commands held between the parser and the drain.
  localparam int QUEUE_DEPTH = 2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_MSG      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CSUM_ERR = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK   = 2'd2;

  // Configuration reset values.
  localparam logic [BYTE_W-1:0] START_RST  = 8'd126;
  localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'd125;
  localparam logic [BYTE_W-1:0] MASK_RST   = 8'd32;

  // One finished frame as the drain sees it.
  typedef struct packed {
    logic [STATUS_W-1:0] kind;
    logic                bank;
    logic [CNT_W-1:0]    count;
  } cmd_t;

  // The drain hands a store bank back to the parser.
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

endpackage

// ===== rtl/core/sfr_ram.sv =====
module sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/sfr_queue.sv =====
module sfr_queue
  import sfr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entry [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] fill;

  assign full       = (fill == NW'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_cmd   = entry[rd_ptr];

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // The fill level never runs past the depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= NW'(QUEUE_DEPTH))
    else $error("queue fill level beyond its depth");

endmodule

// ===== rtl/core/sfr_front.sv =====
module sfr_front
  import sfr_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [BYTE_W-1:0]             cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [BYTE_W-1:0]             s_tdata,
  output logic                          wr_en,
  output logic [$clog2(2*STORE_DEPTH)-1:0] wr_addr,
  output logic [BYTE_W-1:0]             wr_data,
  output logic                          push,
  output cmd_t                          push_cmd,
  input  logic                          q_full,
  input  release_t                      rel
);

  localparam int USABLE = (STORE_DEPTH < 16) ? STORE_DEPTH : 16;
  localparam int AW     = $clog2(2 * STORE_DEPTH);

  logic [BYTE_W-1:0] start_marker;
  logic [BYTE_W-1:0] escape_marker;
  logic [BYTE_W-1:0] escape_mask;

  logic              after_start;
  logic              after_escape;
  logic signed [8:0] bytes_left;
  logic [BYTE_W-1:0] running_sum;
  logic [CNT_W-1:0]  fill_index;
  logic              too_long;
  logic              bank;
  logic [1:0]        bank_busy;

  logic              accept;
  logic              is_start;
  logic              idle_byte;
  logic              is_escape;
  logic [BYTE_W-1:0] unesc;
  logic [BYTE_W-1:0] sum_new;
  logic              data_byte;
  logic              length_byte;
  logic              msg_byte;
  logic              csum_byte;
  logic              good_frame;

  // A byte is taken while a command slot is free and the open bank is not draining.
  assign s_tready = !q_full && !bank_busy[bank];
  assign accept   = s_tvalid && s_tready;

  // Classify the incoming byte.
  always_comb begin
    is_start    = (s_tdata == start_marker);
    idle_byte   = !is_start && !after_start && bytes_left[8];
    is_escape   = !is_start && !idle_byte && !after_escape && (s_tdata == escape_marker);
    data_byte   = accept && !is_start && !idle_byte && !is_escape;
    unesc       = after_escape ? (s_tdata ^ escape_mask) : s_tdata;
    sum_new     = running_sum + unesc;
    length_byte = data_byte && after_start;
    msg_byte    = data_byte && !after_start && (bytes_left != '0);
    csum_byte   = data_byte && !after_start && (bytes_left == '0);
    good_frame  = !too_long && (sum_new == '0);
  end

  // Store write of a message byte into the open bank.
  always_comb begin
    wr_en   = msg_byte && !too_long && (fill_index < CNT_W'(USABLE));
    wr_addr = bank ? AW'(STORE_DEPTH) + AW'(fill_index) : AW'(fill_index);
    wr_data = unesc;
  end

  // Frame command at the checksum byte; a good empty frame gives none.
  always_comb begin
    push           = csum_byte && !(good_frame && (fill_index == '0));
    push_cmd.bank  = bank;
    push_cmd.count = fill_index;
    if (too_long) begin
      push_cmd.kind = ST_TOO_LONG;
    end else if (sum_new != '0) begin
      push_cmd.kind = ST_CSUM_ERR;
    end else begin
      push_cmd.kind = ST_MSG;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker  <= START_RST;
      escape_marker <= ESCAPE_RST;
      escape_mask   <= MASK_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_START:  start_marker  <= cfg_data;
        CFG_ESCAPE: escape_marker <= cfg_data;
        CFG_MASK:   escape_mask   <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      after_start  <= 1'b0;
      after_escape <= 1'b0;
      bytes_left   <= -9'sd1;
      running_sum  <= '0;
      fill_index   <= '0;
      too_long     <= 1'b0;
    end else if (accept) begin
      if (is_start) begin
        after_start  <= 1'b1;
        after_escape <= 1'b0;
      end else if (is_escape) begin
        after_escape <= 1'b1;
      end else if (length_byte) begin
        after_escape <= 1'b0;
        after_start  <= 1'b0;
        bytes_left   <= $signed({1'b0, unesc});
        running_sum  <= '0;
        fill_index   <= '0;
        too_long     <= (unesc > BYTE_W'(USABLE));
      end else if (data_byte) begin
        after_escape <= 1'b0;
        running_sum  <= sum_new;
        bytes_left   <= bytes_left - 9'sd1;
        if (wr_en) begin
          fill_index <= fill_index + 1'b1;
        end
      end
    end
  end

  // Bank ownership: a good frame hands its bank to the drain until it is sent.
  always_ff @(posedge clk) begin
    if (rst) begin
      bank      <= 1'b0;
      bank_busy <= '0;
    end else begin
      if (rel.valid) begin
        bank_busy[rel.bank] <= 1'b0;
      end
      if (push && (push_cmd.kind == ST_MSG)) begin
        bank_busy[bank] <= 1'b1;
        bank            <= !bank;
      end
    end
  end

  // The parser never writes into a bank the drain still owns.
  a_no_busy_write: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !bank_busy[bank])
    else $error("store write into a draining bank");

  // Commands are pushed only when the queue has room.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("command push into a full queue");

endmodule

// ===== rtl/core/sfr_back.sv =====
module sfr_back
  import sfr_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  cmd_t                             q_cmd,
  output logic                             pop,
  output logic                             rd_en,
  output logic [$clog2(2*STORE_DEPTH)-1:0] rd_addr,
  input  logic [BYTE_W-1:0]                rd_data,
  output release_t                         rel,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [M_TDATA_W-1:0]             m_tdata,
  output logic [STATUS_W-1:0]              m_tuser,
  output logic                             m_tlast
);

  localparam int AW = $clog2(2 * STORE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]          state;
  logic [1:0]          state_next;
  cmd_t                cur;
  logic [CNT_W-1:0]    idx;
  logic [CNT_W-1:0]    rd_idx;
  logic                rd_bank;
  logic [STATUS_W-1:0] out_status;
  logic [BYTE_W-1:0]   out_payload;
  logic [POS_W-1:0]    out_pos;
  logic                out_last;
  logic                beat_done;

  assign m_tvalid  = (state == S_HOLD);
  assign m_tdata   = {{(M_TDATA_W - BYTE_W - POS_W){1'b0}}, out_pos, out_payload};
  assign m_tuser   = out_status;
  assign m_tlast   = out_last;
  assign beat_done = m_tvalid && m_tready;
  assign pop       = (state == S_IDLE) && q_valid;

  // Store read: the first byte on a new data frame, the next one after each beat but the last.
  always_comb begin
    rd_en   = 1'b0;
    rd_idx  = '0;
    rd_bank = q_cmd.bank;
    if (pop && (q_cmd.kind == ST_MSG)) begin
      rd_en = 1'b1;
    end else if (beat_done && !out_last) begin
      rd_en   = 1'b1;
      rd_idx  = idx + 1'b1;
      rd_bank = cur.bank;
    end
    rd_addr = rd_bank ? AW'(STORE_DEPTH) + AW'(rd_idx) : AW'(rd_idx);
  end

  // Hand the bank back once the last byte of a data frame is taken.
  always_comb begin
    rel.valid = beat_done && out_last && (out_status == ST_MSG);
    rel.bank  = cur.bank;
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (pop) begin
          state_next = (q_cmd.kind == ST_MSG) ? S_READ : S_HOLD;
        end
      end
      S_READ: state_next = S_HOLD;
      S_HOLD: begin
        if (beat_done) begin
          state_next = out_last ? S_IDLE : S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register and frame bookkeeping.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur         <= q_cmd;
      idx         <= '0;
      out_status  <= q_cmd.kind;
      out_payload <= '0;
      out_pos     <= '0;
      out_last    <= 1'b1;
    end else if (state == S_READ) begin
      out_payload <= rd_data;
      out_pos     <= POS_W'(idx);
      out_last    <= (idx + 1'b1 == cur.count);
    end else if (beat_done && !out_last) begin
      idx <= idx + 1'b1;
    end
  end

  // An error beat is always the last one, with zero payload and position.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ST_MSG)) |-> (m_tlast && (m_tdata == '0)))
    else $error("error beat not closed or not zeroed");

  // A read issued for a frame byte is shown once the store data has passed into the output register.
  a_read_to_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> m_tvalid)
    else $error("store read not followed by an output beat");

endmodule

// ===== rtl/core/stuffed_frame_receiver_core.sv =====
// Channel  Direction  Beat contents
// s        in         tdata[7:0] raw_byte
// m        out        tdata[7:0] payload, [11:8] position; tuser status; tlast last
// cfg      in         cfg_index register index, cfg_data value; always ready
//
// The parser takes one link byte per cycle. It stalls only while the command
// queue is full or while the store bank it would fill is still being drained.
// Each message beat in the drain takes a store read, then the output register;
// an error beat is loaded into the output register as its command is popped.
// Reset clears all control state and restores the configuration registers; the
// message store is not cleared and needs no clearing pass.
module stuffed_frame_receiver_core
  import sfr_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [BYTE_W-1:0]     cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [BYTE_W-1:0]     s_tdata,   // raw_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // payload, position, zero fill
  output logic [STATUS_W-1:0]   m_tuser,   // status
  output logic                  m_tlast
);

  localparam int AW = $clog2(2 * STORE_DEPTH);

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [BYTE_W-1:0] rd_data;
  logic              push;
  cmd_t              push_cmd;
  logic              q_full;
  logic              pop;
  logic              q_valid;
  cmd_t              q_cmd;
  release_t          rel;

  assign cfg_ready = 1'b1;

  sfr_front #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full),
    .rel      (rel)
  );

  // Two banks, so one frame can fill while the previous one drains.
  sfr_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(2 * STORE_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  sfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .head_valid(q_valid),
    .head_cmd  (q_cmd)
  );

  sfr_back #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .pop     (pop),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .rel     (rel),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule
